@@ rtl/pid_pkg.sv @@
// ----------------------------------------------------------------------------
// pid_pkg: shared types and helpers of the positional PID controller
// Register indexes, divider request and response, 32-bit saturation.
// ----------------------------------------------------------------------------
package pid_pkg;

  typedef enum logic [2:0] {
    CFG_PROP_GAIN     = 3'd0,
    CFG_INTEG_GAIN    = 3'd1,
    CFG_DERIV_GAIN    = 3'd2,
    CFG_SAMPLE_PERIOD = 3'd3,
    CFG_MODE_BITS     = 3'd4,
    CFG_DERIV_COEFF   = 3'd5,
    CFG_INTEG_BOUND   = 3'd6,
    CFG_OUTPUT_LIMIT  = 3'd7
  } cfg_idx_e;

  localparam logic [1:0] IMODE_SEPARATED  = 2'd1;
  localparam logic [1:0] IMODE_ANTIWINDUP = 2'd2;
  localparam logic [1:0] DMODE_FILTERED   = 2'd1;
  localparam logic [1:0] DMODE_SETPOINT   = 2'd2;

  typedef struct packed {
    logic               start;
    logic signed [63:0] dividend;
    logic signed [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/pid_ifs.sv @@
// ----------------------------------------------------------------------------
// pid_ifs: channel interfaces of the positional PID controller
// Sample request, drive response and register write channels.
// ----------------------------------------------------------------------------
interface pid_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] setpoint;
  logic signed [31:0] measured;
  modport source(output valid, setpoint, measured, input ready);
  modport sink(input valid, setpoint, measured, output ready);
endinterface

interface pid_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  modport source(output valid, drive, input ready);
  modport sink(input valid, drive, output ready);
endinterface

interface pid_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/pid_mul.sv @@
// ----------------------------------------------------------------------------
// pid_mul: shared signed multiplier
// 33 x 33 signed product, registered.
// ----------------------------------------------------------------------------
module pid_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);
  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;
endmodule

@@ rtl/pid_div.sv @@
// ----------------------------------------------------------------------------
// pid_div: shared iterative signed divider
// 64 / 32 bit, truncating, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module pid_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pid_pkg::div_req_t   req_i,
  output pid_pkg::div_rsp_t   rsp_o
);
  import pid_pkg::*;

  logic        busy_q, done_q, neg_q;
  logic [3:0]  cnt_q;
  logic [32:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] den_q;

  always_comb begin
    logic [32:0] r;
    logic [63:0] q;
    r = rem_q;
    q = quo_q;
    for (int k = 0; k < 4; k++) begin
      r = {r[31:0], q[63]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, den_q}) begin
        r = r - {1'b0, den_q};
        q[0] = 1'b1;
      end
    end
    rem_d = r;
    quo_d = q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.dividend[63] ^ req_i.divisor[31];
      rem_q <= '0;
      quo_q <= req_i.dividend[63] ? 64'(-req_i.dividend) : 64'(req_i.dividend);
      den_q <= req_i.divisor[31] ? 32'(-req_i.divisor) : 32'(req_i.divisor);
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
endmodule

@@ rtl/positional_pid_controller.sv @@
// ----------------------------------------------------------------------------
// positional_pid_controller: positional PID controller, signed Q16.16
// A sample enters on req_i (setpoint, measured) and one drive value leaves on
// rsp_o. Registers are to be written on cfg_i (index 0..7) by the user only
// while the block is idle, which it does not enforce; cfg_i is always ready.
// The drive is worked out in the states ST_INC, ST_AWP, ST_INTEG, ST_IDIV
// (only when the anti-windup limit quotient is needed), ST_DER1, ST_DER2,
// ST_DERC, ST_PROP, ST_INT, ST_DRV, ST_DDS and ST_DDIV, then held in ST_OUT.
// These steps use the shared 33x33 multiplier (one registered product a
// cycle, seven products) and the shared divider (four quotient bits a cycle)
// used for the derivative divide by the sample period and for the windup
// limit quotient. With the run bit clear the drive is valid the cycle after
// the sample is taken.
// One sample is in work at a time: req_i.ready is high only when idle and
// the previous drive has been taken. A stalled rsp_o holds drive and
// keeps req_i closed.
// Reset clears the integral, previous error, filtered derivative and
// previous setpoint and loads the register defaults.
// ----------------------------------------------------------------------------
module positional_pid_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  pid_cfg_if.sink       cfg_i,
  pid_req_if.sink       req_i,
  pid_rsp_if.source     rsp_o
);
  import pid_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INC, ST_AWP, ST_INTEG, ST_IDIV, ST_DER1, ST_DER2, ST_DERC,
    ST_PROP, ST_INT, ST_DRV, ST_DDS, ST_DDIV, ST_OUT
  } state_e;

  state_e state_q;

  logic signed [31:0] kp_q, ki_q, kd_q, coeff_q, bound_q, olim_q;
  logic [30:0]        period_q;
  logic [5:0]         mode_q;

  logic signed [31:0] isum_q, perr_q, fd_q, psp_q;
  logic signed [31:0] sp_q, e_q, d_q, drive_q;
  logic signed [49:0] inc_q, t1_q;
  logic signed [65:0] acc_q;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic [30:0]        teff;
  logic signed [32:0] raw;
  logic signed [65:0] lim, sum_i, dsum;
  logic signed [31:0] e_n, dn, drv_sat, isum_plain;
  logic signed [32:0] olim_neg;

  pid_mul u_mul (.clk_i(clk_i), .a_i(ma), .b_i(mb), .p_o(mp));
  pid_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = (state_q == ST_OUT);
  assign rsp_o.drive = drive_q;

  always_comb begin
    teff       = (period_q == '0) ? 31'd1 : period_q;
    e_n        = sat32(66'(req_i.setpoint) - 66'(req_i.measured));
    raw        = 33'(e_q) - 33'(perr_q);
    lim        = {{18{bound_q[31]}}, bound_q, 16'h0000};
    sum_i      = 66'(isum_q) + 66'(inc_q);
    isum_plain = sat32(sum_i);
    olim_neg   = -33'(olim_q);
    dsum       = acc_q + 66'(drsp.quotient);
    drv_sat    = sat32(dsum);
    unique case (mode_q[4:3])
      DMODE_FILTERED: dn = sat32(66'(t1_q) + 66'(mp >>> 16));
      DMODE_SETPOINT: dn = sat32(66'(raw) - 66'(t1_q));
      default:        dn = sat32(66'(raw));
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      ST_INC: begin
        ma = mode_q[2] ? 33'(e_q) + 33'(perr_q) : 33'(e_q);
        mb = 33'(teff);
      end
      ST_AWP: begin
        ma = 33'(isum_q);
        mb = 33'(ki_q);
      end
      ST_DER1: begin
        ma = (mode_q[4:3] == DMODE_SETPOINT) ? 33'(sp_q) - 33'(psp_q)
                                             : 33'(sat32(66'(raw)));
        mb = 33'(coeff_q);
      end
      ST_DER2: begin
        ma = 33'sd65536 - 33'(coeff_q);
        mb = 33'(fd_q);
      end
      ST_PROP: begin
        ma = 33'(kp_q);
        mb = 33'(e_q);
      end
      ST_INT: begin
        ma = 33'(ki_q);
        mb = 33'(isum_q);
      end
      ST_DRV: begin
        ma = 33'(kd_q);
        mb = 33'(d_q);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = mp[63:0];
    dreq.divisor  = 32'(teff);
    if (state_q == ST_INTEG) begin
      dreq.divisor  = ki_q;
      dreq.dividend = (mp > lim) ? lim[63:0] : 64'(-lim);
      dreq.start    = (ki_q != '0) && (mode_q[1:0] == IMODE_ANTIWINDUP)
                      && ((mp > lim) || (mp < -lim));
    end else if (state_q == ST_DDS) begin
      dreq.start = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      period_q <= 31'd65536;
      mode_q   <= 6'd32;
      coeff_q  <= '0;
      bound_q  <= -32'sd65536;
      olim_q   <= -32'sd65536;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_PROP_GAIN:     kp_q     <= cfg_i.data;
        CFG_INTEG_GAIN:    ki_q     <= cfg_i.data;
        CFG_DERIV_GAIN:    kd_q     <= cfg_i.data;
        CFG_SAMPLE_PERIOD: period_q <= cfg_i.data[30:0];
        CFG_MODE_BITS:     mode_q   <= cfg_i.data[5:0];
        CFG_DERIV_COEFF:   coeff_q  <= cfg_i.data;
        CFG_INTEG_BOUND:   bound_q  <= cfg_i.data;
        CFG_OUTPUT_LIMIT:  olim_q   <= cfg_i.data;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      isum_q  <= '0;
      perr_q  <= '0;
      fd_q    <= '0;
      psp_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            sp_q <= req_i.setpoint;
            e_q  <= e_n;
            if (mode_q[5]) begin
              state_q <= ST_INC;
            end else begin
              drive_q <= req_i.measured;
              isum_q  <= '0;
              perr_q  <= '0;
              fd_q    <= '0;
              psp_q   <= '0;
              state_q <= ST_OUT;
            end
          end
        end
        ST_INC: state_q <= ST_AWP;
        ST_AWP: begin
          inc_q   <= mode_q[2] ? 50'(mp >>> 17) : 50'(mp >>> 16);
          state_q <= ST_INTEG;
        end
        ST_INTEG: begin
          state_q <= ST_DER1;
          if (ki_q == '0) begin
            isum_q <= '0;
          end else if (mode_q[1:0] == IMODE_SEPARATED) begin
            if (!((33'(e_q) > 33'(bound_q)) || (33'(e_q) < -33'(bound_q)))) begin
              isum_q <= isum_plain;
            end
          end else if (dreq.start) begin
            state_q <= ST_IDIV;
          end else begin
            isum_q <= isum_plain;
          end
        end
        ST_IDIV: begin
          if (drsp.done) begin
            isum_q  <= sat32(66'(drsp.quotient));
            state_q <= ST_DER1;
          end
        end
        ST_DER1: state_q <= ST_DER2;
        ST_DER2: begin
          t1_q    <= 50'(mp >>> 16);
          state_q <= ST_DERC;
        end
        ST_DERC: begin
          d_q     <= dn;
          state_q <= ST_PROP;
        end
        ST_PROP: state_q <= ST_INT;
        ST_INT: begin
          acc_q   <= mp >>> 16;
          state_q <= ST_DRV;
        end
        ST_DRV: begin
          acc_q   <= acc_q + (mp >>> 16);
          state_q <= ST_DDS;
        end
        ST_DDS: state_q <= ST_DDIV;
        ST_DDIV: begin
          if (drsp.done) begin
            if (!olim_q[31] && (drv_sat > olim_q)) begin
              drive_q <= olim_q;
            end else if (!olim_q[31] && (33'(drv_sat) < olim_neg)) begin
              drive_q <= olim_neg[31:0];
            end else begin
              drive_q <= drv_sat;
            end
            perr_q  <= e_q;
            psp_q   <= sp_q;
            fd_q    <= d_q;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (rsp_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while a sample is in work");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> (state_q == ST_IDIV || state_q == ST_DDIV))
    else $error("divider finished outside a wait state");

  a_drive_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && mode_q[5] && !olim_q[31])
      |-> (rsp_o.drive <= olim_q && 33'(rsp_o.drive) >= olim_neg))
    else $error("drive outside output limit");
`endif
endmodule

@@ sim/tb_positional_pid_controller.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_pid_controller: self-checking bench of the PID controller
// A queue-fed driver sends samples and a monitor predicts each drive value
// from its own copy of the registers and loop state, then compares every
// response in order. Phases reprogram the registers while idle and vary the
// idling of both sides.
// ----------------------------------------------------------------------------
module tb_positional_pid_controller;
  import pid_pkg::*;

  typedef struct packed {
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pid_cfg_if cfg_ch();
  pid_req_if req_ch();
  pid_rsp_if rsp_ch();

  positional_pid_controller dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch.sink),
    .req_i  (req_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  always #2 clk_i = ~clk_i;

  sample_t        pending_samples[$];
  logic [31:0]    expected_drives[$];
  int             sender_idle_pct = 0;
  int             receiver_idle_pct = 0;
  int             error_count = 0;
  logic           req_taken = 1'b0;

  longint         kp, ki, kd, coeff, bound, drive_clamp;
  longint         period;
  logic [5:0]     mode;
  longint         integ_acc, prev_err, filt_deriv, prev_sp;

  function automatic longint sat32_l(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] predict_drive(sample_t s);
    longint sp, meas, t, e, inc, d, raw, drv, prod, lim;
    sp = longint'(s.setpoint);
    meas = longint'(s.measured);
    if (!mode[5]) begin
      integ_acc = 0;
      prev_err = 0;
      filt_deriv = 0;
      prev_sp = 0;
      return s.measured;
    end
    t = (period == 0) ? 1 : period;
    e = sat32_l(sp - meas);
    if (mode[2]) begin
      inc = ((e + prev_err) * t) >>> 17;
    end else begin
      inc = (e * t) >>> 16;
    end
    if (ki == 0) begin
      integ_acc = 0;
    end else if (mode[1:0] == IMODE_SEPARATED) begin
      if (!(e > bound || e < -bound)) integ_acc = sat32_l(integ_acc + inc);
    end else if (mode[1:0] == IMODE_ANTIWINDUP) begin
      prod = integ_acc * ki;
      lim = bound * 65536;
      if (prod > lim) begin
        integ_acc = sat32_l(lim / ki);
      end else if (prod < -lim) begin
        integ_acc = sat32_l(-lim / ki);
      end else begin
        integ_acc = sat32_l(integ_acc + inc);
      end
    end else begin
      integ_acc = sat32_l(integ_acc + inc);
    end
    raw = e - prev_err;
    if (mode[4:3] == DMODE_FILTERED) begin
      raw = sat32_l(raw);
      d = sat32_l(((coeff * raw) >>> 16) + (((65536 - coeff) * filt_deriv) >>> 16));
    end else if (mode[4:3] == DMODE_SETPOINT) begin
      d = sat32_l(raw - ((coeff * (sp - prev_sp)) >>> 16));
    end else begin
      d = sat32_l(raw);
    end
    filt_deriv = d;
    drv = ((kp * e) >>> 16) + ((ki * integ_acc) >>> 16) + (kd * d) / t;
    drv = sat32_l(drv);
    if (drive_clamp >= 0) begin
      if (drv > drive_clamp) drv = drive_clamp;
      else if (drv < -drive_clamp) drv = -drive_clamp;
    end
    prev_sp = sp;
    prev_err = e;
    return drv[31:0];
  endfunction

  task automatic apply_register(cfg_idx_e idx, logic [31:0] val);
    case (idx)
      CFG_PROP_GAIN:     kp = longint'($signed(val));
      CFG_INTEG_GAIN:    ki = longint'($signed(val));
      CFG_DERIV_GAIN:    kd = longint'($signed(val));
      CFG_SAMPLE_PERIOD: period = longint'({33'd0, val[30:0]});
      CFG_MODE_BITS:     mode = val[5:0];
      CFG_DERIV_COEFF:   coeff = longint'($signed(val));
      CFG_INTEG_BOUND:   bound = longint'($signed(val));
      default:           drive_clamp = longint'($signed(val));
    endcase
  endtask

  // monitor: predict on accepted samples, check accepted drives
  always @(posedge clk_i) begin
    logic [31:0] want;
    req_taken <= req_ch.valid && req_ch.ready;
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      apply_register(cfg_idx_e'(cfg_ch.index), cfg_ch.data);
    end
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      expected_drives.push_back(predict_drive({req_ch.setpoint, req_ch.measured}));
    end
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected drive %h", $time, rsp_ch.drive);
        error_count++;
      end else begin
        want = expected_drives.pop_front();
        if (rsp_ch.drive !== want) begin
          $display("%0t: drive expected %h actual %h", $time, want, rsp_ch.drive);
          error_count++;
        end
      end
    end
  end

  // driver: present queued samples, hold until the transaction completes
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      if (!req_ch.valid || req_taken) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          req_ch.valid <= 1'b1;
          {req_ch.setpoint, req_ch.measured} <= pending_samples.pop_front();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.setpoint = '0;
    req_ch.measured = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
  end

  task automatic write_register(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || req_ch.valid || expected_drives.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value(int small_span);
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom();
      3: return '0;
      default: return $urandom_range(2 * small_span) - small_span;
    endcase
  endfunction

  task automatic program_all(logic [31:0] v[8]);
    for (int i = 0; i < 8; i++) write_register(cfg_idx_e'(i), v[i]);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_sample(logic [31:0] sp, logic [31:0] meas);
    pending_samples.push_back({sp, meas});
  endtask

  initial begin
    logic [31:0] regs[8];
    kp = 0; ki = 0; kd = 0; period = 65536; mode = 6'd32; coeff = 0;
    bound = -65536; drive_clamp = -65536;
    integ_acc = 0; prev_err = 0; filt_deriv = 0; prev_sp = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: default registers, then extremes under each mode
    push_sample(32'h7FFF_FFFF, 32'h8000_0000);
    push_sample(32'h8000_0000, 32'h7FFF_FFFF);
    wait_drained();
    regs = '{32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'd0, 32'h3F,
             32'h0000_8000, 32'h0002_0000, 32'h0010_0000};
    for (int m = 0; m < 4; m++) begin
      regs[4] = (m == 0) ? 32'h20 : (m == 1) ? 32'h2D : (m == 2) ? 32'h36 : 32'h1F;
      regs[3] = (m == 0) ? 32'd0 : (m == 1) ? 32'd1 : 32'h7FFF_FFFF;
      program_all(regs);
      push_sample(32'h7FFF_FFFF, 32'h8000_0000);
      push_sample(32'h8000_0000, 32'h7FFF_FFFF);
      push_sample(32'h0001_0000, 32'h0);
      push_sample(32'h0, 32'h0001_8000);
      push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      wait_drained();
    end

    for (int p = 0; p < 12; p++) begin
      sender_idle_pct = (p < 4) ? 27 : (p < 8) ? 74 : 0;
      receiver_idle_pct = (p < 4) ? 74 : (p < 8) ? 27 : 0;
      for (int i = 0; i < 8; i++) regs[i] = pick_value(1 << 18);
      if (p == 0) regs = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h3F, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      if (p == 1) regs = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0,
                           32'h0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
      if (p > 1) begin
        regs[4] = {26'd0, $urandom_range(9) != 0, 5'($urandom())};
        if ($urandom_range(3) != 0) regs[3] = $urandom_range(1 << 18);
      end
      program_all(regs);
      for (int n = 0; n < 150; n++) begin
        push_sample(pick_value(1 << 20), pick_value(1 << 20));
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pid_pkg.sv
rtl/pid_ifs.sv
rtl/pid_mul.sv
rtl/pid_div.sv
rtl/positional_pid_controller.sv
sim/tb_positional_pid_controller.sv
